@@ rtl/complex_arith_unit_macros.svh @@
// assertion helpers for the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// same-cycle implication on clk, masked during reset
`define CAU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_arith_unit check failed");

// next-cycle implication on clk, masked during reset
`define CAU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex_arith_unit check failed");

`endif

@@ rtl/cau_pkg.sv @@
`timescale 1ns / 1ps
package cau_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int DATA_W        = 32;
    localparam int QUO_W         = 33;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_SQR  = 2'd0,
        OP_MUL  = 2'd1,
        OP_DIV  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic              valid;
        op_t               op;
        logic              dbz;
        logic              neg_re;
        logic              neg_im;
        logic              big_re;
        logic              big_im;
        logic              mul_ovf;
        logic [DATA_W-1:0] mul_re;
        logic [DATA_W-1:0] mul_im;
    } cau_ctl_t;

    typedef struct packed {
        logic [63:0]      den;
        logic [63:0]      rem_re;
        logic [63:0]      rem_im;
        logic [QUO_W-1:0] quo_re;
        logic [QUO_W-1:0] quo_im;
    } cau_div_t;

endpackage

@@ rtl/cau_req_if.sv @@
`timescale 1ns / 1ps
interface cau_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] x_real;
    logic signed [31:0] x_imag;
    logic signed [31:0] y_real;
    logic signed [31:0] y_imag;

    modport source (output valid, opcode, x_real, x_imag, y_real, y_imag, input ready);
    modport sink   (input valid, opcode, x_real, x_imag, y_real, y_imag, output ready);
endinterface

@@ rtl/cau_rsp_if.sv @@
`timescale 1ns / 1ps
interface cau_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic               overflow;
    logic               divide_by_zero;

    modport source (output valid, res_real, res_imag, overflow, divide_by_zero,
                    input ready);
    modport sink   (input valid, res_real, res_imag, overflow, divide_by_zero,
                    output ready);
endinterface

@@ rtl/cau_front.sv @@
`timescale 1ns / 1ps
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    cau_req_if.sink           req,
    output cau_pkg::cau_ctl_t ctl_o,
    output cau_pkg::cau_div_t div_o
);
    import cau_pkg::*;

    localparam int SH = QUO_W - FRAC_BITS;

    function automatic logic [DATA_W:0] sat_shift(input logic signed [64:0] s);
        logic signed [64:0] sh;
        logic [DATA_W:0]    r;
        sh = s >>> FRAC_BITS;
        if (sh[64:31] == '0 || sh[64:31] == '1)
            r = {1'b0, sh[31:0]};
        else
            r = {1'b1, (sh[64] ? SAT_MIN : SAT_MAX)};
        return r;
    endfunction

    // stage 1: operand capture
    op_t                op_in;
    logic signed [31:0] c_sel, d_sel;
    logic               v1_reg;
    op_t                op1_reg;
    logic signed [31:0] a1_reg, b1_reg, c1_reg, d1_reg;

    assign op_in = op_t'(req.opcode);
    assign c_sel = (op_in == OP_SQR) ? req.x_real : req.y_real;
    assign d_sel = (op_in == OP_SQR) ? req.x_imag : req.y_imag;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= req.valid;
            op1_reg <= op_in;
            a1_reg  <= req.x_real;
            b1_reg  <= req.x_imag;
            c1_reg  <= c_sel;
            d1_reg  <= d_sel;
        end
    end

    // stage 2: partial products
    logic               v2_reg;
    op_t                op2_reg;
    logic signed [63:0] pac_next, pbd_next, pad_next, pbc_next, pcc_next, pdd_next;
    logic signed [63:0] pac_reg, pbd_reg, pad_reg, pbc_reg, pcc_reg, pdd_reg;

    assign pac_next = a1_reg * c1_reg;
    assign pbd_next = b1_reg * d1_reg;
    assign pad_next = a1_reg * d1_reg;
    assign pbc_next = b1_reg * c1_reg;
    assign pcc_next = c1_reg * c1_reg;
    assign pdd_next = d1_reg * d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg  <= v1_reg;
            op2_reg <= op1_reg;
            pac_reg <= pac_next;
            pbd_reg <= pbd_next;
            pad_reg <= pad_next;
            pbc_reg <= pbc_next;
            pcc_reg <= pcc_next;
            pdd_reg <= pdd_next;
        end
    end

    // stage 3: exact sums
    logic               v3_reg;
    op_t                op3_reg;
    logic signed [64:0] sre_next, sim_next, sre_reg, sim_reg;
    logic        [63:0] den_next, den3_reg;

    always_comb
    begin
        if (op2_reg == OP_DIV)
        begin
            sre_next = {pac_reg[63], pac_reg} + {pbd_reg[63], pbd_reg};
            sim_next = {pbc_reg[63], pbc_reg} - {pad_reg[63], pad_reg};
        end
        else
        begin
            sre_next = {pac_reg[63], pac_reg} - {pbd_reg[63], pbd_reg};
            sim_next = {pad_reg[63], pad_reg} + {pbc_reg[63], pbc_reg};
        end
        den_next = $unsigned(pcc_reg) + $unsigned(pdd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg   <= v2_reg;
            op3_reg  <= op2_reg;
            sre_reg  <= sre_next;
            sim_reg  <= sim_next;
            den3_reg <= den_next;
        end
    end

    // stage 4: product rounding and saturation, quotient sign and magnitude
    logic        [DATA_W:0] satre_next, satim_next;
    logic        [64:0]     magre_full, magim_full;
    logic                   v4_reg;
    op_t                    op4_reg;
    logic                   dbz4_reg, negre4_reg, negim4_reg, mulovf4_reg;
    logic        [63:0]     magre4_reg, magim4_reg, den4_reg;
    logic        [31:0]     mulre4_reg, mulim4_reg;

    assign satre_next = sat_shift(sre_reg);
    assign satim_next = sat_shift(sim_reg);
    assign magre_full = sre_reg[64] ? 65'(-sre_reg) : 65'(sre_reg);
    assign magim_full = sim_reg[64] ? 65'(-sim_reg) : 65'(sim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg      <= v3_reg;
            op4_reg     <= op3_reg;
            dbz4_reg    <= (den3_reg == '0);
            negre4_reg  <= sre_reg[64];
            negim4_reg  <= sim_reg[64];
            magre4_reg  <= magre_full[63:0];
            magim4_reg  <= magim_full[63:0];
            den4_reg    <= den3_reg;
            mulre4_reg  <= satre_next[DATA_W-1:0];
            mulim4_reg  <= satim_next[DATA_W-1:0];
            mulovf4_reg <= satre_next[DATA_W] | satim_next[DATA_W];
        end
    end

    // stage 5: divider seed and quotient range check
    logic [63:0] magre_sl, magim_sl;
    cau_ctl_t    ctl_next, ctl_reg;
    cau_div_t    div_next, div_reg;

    assign magre_sl = magre4_reg << FRAC_BITS;
    assign magim_sl = magim4_reg << FRAC_BITS;

    always_comb
    begin
        div_next.den    = den4_reg;
        div_next.rem_re = magre4_reg >> SH;
        div_next.rem_im = magim4_reg >> SH;
        div_next.quo_re = magre_sl[QUO_W-1:0];
        div_next.quo_im = magim_sl[QUO_W-1:0];
        ctl_next.valid   = v4_reg;
        ctl_next.op      = op4_reg;
        ctl_next.dbz     = dbz4_reg;
        ctl_next.neg_re  = negre4_reg;
        ctl_next.neg_im  = negim4_reg;
        ctl_next.big_re  = (div_next.rem_re >= den4_reg);
        ctl_next.big_im  = (div_next.rem_im >= den4_reg);
        ctl_next.mul_ovf = mulovf4_reg;
        ctl_next.mul_re  = mulre4_reg;
        ctl_next.mul_im  = mulim4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
            div_reg <= div_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign div_o = div_reg;
endmodule

@@ rtl/cau_div_stage.sv @@
`timescale 1ns / 1ps
module cau_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  cau_pkg::cau_ctl_t ctl_i,
    input  cau_pkg::cau_div_t div_i,
    output cau_pkg::cau_ctl_t ctl_o,
    output cau_pkg::cau_div_t div_o
);
    import cau_pkg::*;

    // one restoring step for both lanes against the shared divisor
    logic [64:0] tre, tim, dre, dim;
    logic        ge_re, ge_im;
    cau_div_t    div_next, div_reg;
    cau_ctl_t    ctl_reg;

    always_comb
    begin
        tre   = {div_i.rem_re, div_i.quo_re[QUO_W-1]};
        tim   = {div_i.rem_im, div_i.quo_im[QUO_W-1]};
        dre   = tre - {1'b0, div_i.den};
        dim   = tim - {1'b0, div_i.den};
        ge_re = !dre[64];
        ge_im = !dim[64];
        div_next.den    = div_i.den;
        div_next.rem_re = ge_re ? dre[63:0] : tre[63:0];
        div_next.rem_im = ge_im ? dim[63:0] : tim[63:0];
        div_next.quo_re = {div_i.quo_re[QUO_W-2:0], ge_re};
        div_next.quo_im = {div_i.quo_im[QUO_W-2:0], ge_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_i;
            div_reg <= div_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign div_o = div_reg;
endmodule

@@ rtl/cau_back.sv @@
`timescale 1ns / 1ps
module cau_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  cau_pkg::cau_ctl_t ctl_i,
    input  cau_pkg::cau_div_t div_i,
    cau_rsp_if.source         rsp
);
    import cau_pkg::*;

    function automatic logic [DATA_W:0] quo_sat(input logic [QUO_W-1:0] q, input logic neg,
                                                 input logic big);
        logic [QUO_W-1:0] nq;
        logic             ovf;
        logic [DATA_W:0]  r;
        nq = '0 - q;
        if (neg)
        begin
            ovf = big || q[32] || (q[31] && q[30:0] != '0);
            r   = {ovf, (ovf ? SAT_MIN : nq[31:0])};
        end
        else
        begin
            ovf = big || q[32] || q[31];
            r   = {ovf, (ovf ? SAT_MAX : q[31:0])};
        end
        return r;
    endfunction

    logic [DATA_W:0]   qre, qim;
    logic [DATA_W-1:0] re_next, im_next;
    logic              ovf_next, dbz_next;
    logic              valid_reg, ovf_reg, dbz_reg;
    logic [DATA_W-1:0] re_reg, im_reg;

    assign qre = quo_sat(div_i.quo_re, ctl_i.neg_re, ctl_i.big_re);
    assign qim = quo_sat(div_i.quo_im, ctl_i.neg_im, ctl_i.big_im);

    always_comb
    begin
        re_next  = '0;
        im_next  = '0;
        ovf_next = 1'b0;
        dbz_next = 1'b0;
        case (ctl_i.op)
            OP_SQR, OP_MUL:
            begin
                re_next  = ctl_i.mul_re;
                im_next  = ctl_i.mul_im;
                ovf_next = ctl_i.mul_ovf;
            end
            OP_DIV:
            begin
                if (ctl_i.dbz)
                begin
                    dbz_next = 1'b1;
                end
                else
                begin
                    re_next  = qre[DATA_W-1:0];
                    im_next  = qim[DATA_W-1:0];
                    ovf_next = qre[DATA_W] | qim[DATA_W];
                end
            end
            default:
            begin
                re_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_i.valid;
            re_reg    <= re_next;
            im_reg    <= im_next;
            ovf_reg   <= ovf_next;
            dbz_reg   <= dbz_next;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.res_real       = re_reg;
    assign rsp.res_imag       = im_reg;
    assign rsp.overflow       = ovf_reg;
    assign rsp.divide_by_zero = dbz_reg;
endmodule

@@ rtl/complex_arith_unit.sv @@
`timescale 1ns / 1ps
// complex arithmetic unit: square, multiply or divide of signed fixed-point complex values
// req channel carries opcode, x_real, x_imag, y_real, y_imag; a transaction completes when
//   valid and ready are both high at a rising clk edge
// rsp channel carries res_real, res_imag, overflow and divide_by_zero, one
//   transaction per request, in request order
// pipeline, the same path for every opcode:
//   5 operand/product/sum/prep stages, 33 one-bit divider stages, 1 output stage
// throughput: one transaction per cycle while rsp is not stalled; the 33-stage restoring divider sets the depth
// every stage moves together on one enable; req ready is high while the output register
//   is empty or being drained in the same cycle
// when the receiver holds rsp ready low with rsp valid high, the whole pipe freezes,
//   the result is held and req ready drops; nothing is dropped or repeated
// rst_n is asynchronous, active low; it clears all valid bits, no transaction is in
//   flight after reset and req ready is high
module complex_arith_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cau_req_if.sink   req,
    cau_rsp_if.source rsp
);
    import cau_pkg::*;

    logic     en;
    cau_ctl_t ctl_pipe [0:QUO_W];
    cau_div_t div_pipe [0:QUO_W];

    assign en = !rsp.valid || rsp.ready;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .req   (req),
        .ctl_o (ctl_pipe[0]),
        .div_o (div_pipe[0])
    );

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div
        cau_div_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .ctl_i (ctl_pipe[i]),
            .div_i (div_pipe[i]),
            .ctl_o (ctl_pipe[i+1]),
            .div_o (div_pipe[i+1])
        );
    end

    cau_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ctl_i (ctl_pipe[QUO_W]),
        .div_i (div_pipe[QUO_W]),
        .rsp   (rsp)
    );
endmodule

@@ rtl/cau_checker.sv @@
`timescale 1ns / 1ps
`include "complex_arith_unit_macros.svh"
module cau_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] res_real,
    input logic [31:0] res_imag,
    input logic        overflow,
    input logic        divide_by_zero
);
    import cau_pkg::*;

    logic stalled;
    logic any_sat;
    logic all_zero;

    assign stalled  = out_valid && !out_ready;
    assign any_sat  = (res_real == SAT_MAX) || (res_real == SAT_MIN) ||
                      (res_imag == SAT_MAX) || (res_imag == SAT_MIN);
    assign all_zero = (res_real == '0) && (res_imag == '0) && !overflow;

    `CAU_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(res_real) && $stable(res_imag))
    `CAU_ASSERT_IMP(a_stall_blocks_in, stalled, !in_ready)
    `CAU_ASSERT_IMP(a_dbz_zero, out_valid && divide_by_zero, all_zero)
    `CAU_ASSERT_IMP(a_ovf_sat, out_valid && overflow, any_sat)
endmodule

bind complex_arith_unit cau_assertions u_cau_assertions (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (req.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .res_real       (rsp.res_real),
    .res_imag       (rsp.res_imag),
    .overflow       (rsp.overflow),
    .divide_by_zero (rsp.divide_by_zero)
);

@@ sim/cau_checker.sv @@
`timescale 1ns / 1ps
module cau_checker #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    cau_req_if    req,
    cau_rsp_if    rsp,
    output int    mismatches,
    output int    results_seen,
    output int    pending
);
    import cau_pkg::*;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               ovf;
        logic               dbz;
    } cplx_result_t;

    cplx_result_t result_q[$];

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'sd2147483647)
        begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sd2147483648)
        begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // quotient magnitude truncated toward zero, sign reapplied
    function automatic logic signed [127:0] fx_quot(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< FRAC_BITS) / den;
        if (q > (128'sd1 <<< 33))
            q = 128'sd1 <<< 33;
        return (num < 0) ? -q : q;
    endfunction

    function automatic cplx_result_t compute(input op_t op,
                                             input logic signed [31:0] xr, xi, yr, yi);
        cplx_result_t r;
        logic signed [127:0] a, b, c, d, den;
        a = xr;
        b = xi;
        c = yr;
        d = yi;
        r.re = '0;
        r.im = '0;
        r.ovf = 1'b0;
        r.dbz = 1'b0;
        case (op)
            OP_SQR:
            begin
                r.re = clamp32((a*a - b*b) >>> FRAC_BITS, r.ovf);
                r.im = clamp32((2*a*b) >>> FRAC_BITS, r.ovf);
            end
            OP_MUL:
            begin
                r.re = clamp32((a*c - b*d) >>> FRAC_BITS, r.ovf);
                r.im = clamp32((a*d + b*c) >>> FRAC_BITS, r.ovf);
            end
            OP_DIV:
            begin
                den = c*c + d*d;
                if (den == 0)
                    r.dbz = 1'b1;
                else
                begin
                    r.re = clamp32(fx_quot(a*c + b*d, den), r.ovf);
                    r.im = clamp32(fx_quot(b*c - a*d, den), r.ovf);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cplx_result_t want;
        if (!rst_n)
        begin
            mismatches   <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                result_q.push_back(compute(op_t'(req.opcode), req.x_real, req.x_imag,
                                           req.y_real, req.y_imag));
            if (rsp.valid && rsp.ready)
            begin
                results_seen <= results_seen + 1;
                if (result_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected transaction re=%h im=%h",
                                 rsp.res_real, rsp.res_imag);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (rsp.res_real !== want.re || rsp.res_imag !== want.im ||
                        rsp.overflow !== want.ovf || rsp.divide_by_zero !== want.dbz)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch exp re=%h im=%h ovf=%b dbz=%b ",
                                      "got re=%h im=%h ovf=%b dbz=%b"},
                                     want.re, want.im, want.ovf, want.dbz,
                                     rsp.res_real, rsp.res_imag,
                                     rsp.overflow, rsp.divide_by_zero);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

    assign pending = result_q.size();
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import cau_pkg::*;

    localparam int N_RANDOM = 2000;
    localparam int QUIET_END = 300;
    localparam int WATCHDOG = 2000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   results_seen;
    int   pending;
    int   idle_cycles;
    int   sent;
    int   n_dbz;
    bit   quiet;
    int   gap_left;
    int   stall_left;
    bit   stall;

    cau_req_if req ();
    cau_rsp_if rsp ();

    complex_arith_unit u_dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    cau_checker u_chk (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .mismatches(mismatches), .results_seen(results_seen), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'(signed'($urandom_range(0, 8)) - 4);
            4: return 32'($urandom_range(0, 32'h1FFF_FFFF)) - 32'h1000_0000;
            5: return 32'($urandom_range(0, 16)) << $urandom_range(20, 30);
            default: return $urandom();
        endcase
    endfunction

    task automatic send(input op_t op, input logic [31:0] xr, xi, yr, yi);
        req.valid  <= 1'b1;
        req.opcode <= op;
        req.x_real <= xr;
        req.x_imag <= xi;
        req.y_real <= yr;
        req.y_imag <= yi;
        if (op == OP_DIV && yr == 0 && yi == 0)
            n_dbz++;
        do
            @(posedge clk);
        while (!req.ready);
        sent++;
        if (!quiet && gap_left == 0 && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 10);
        if (gap_left > 0)
        begin
            req.valid <= 1'b0;
            while (gap_left > 0)
            begin
                @(posedge clk);
                gap_left--;
            end
        end
    endtask

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!quiet && $urandom_range(0, 7) == 0)
            stall_left <= $urandom_range(1, 10);
        rsp.ready <= quiet || stall_left == 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("watchdog expired");
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] v [4];
        op_t ops [4];
        ops = '{OP_SQR, OP_MUL, OP_DIV, OP_NONE};
        rst_n = 1'b0;
        quiet = 1'b0;
        gap_left = 0;
        sent = 0;
        n_dbz = 0;
        req.valid = 1'b0;
        req.opcode = '0;
        req.x_real = '0;
        req.x_imag = '0;
        req.y_real = '0;
        req.y_imag = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (ops[i])
        begin
            send(ops[i], 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            send(ops[i], 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            send(ops[i], 32'h1000_0000, 32'hF000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
            send(ops[i], 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0);
            send(ops[i], 32'h0, 32'h0, 32'h2000_0000, 32'h0);
        end
        send(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0);
        send(OP_DIV, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - QUIET_END)
                quiet = 1'b1;
            foreach (v[k])
                v[k] = pick_val();
            if ($urandom_range(0, 9) == 0)
            begin
                v[2] = 0;
                v[3] = 0;
            end
            send(ops[$urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)], v[0], v[1], v[2], v[3]);
        end
        req.valid <= 1'b0;
        quiet = 1'b1;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("sent %0d transactions over all opcodes, %0d divides by zero", sent, n_dbz);
        $display("checked %0d results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
